>>> rtl/epau_pkg.sv
// Package for the error propagating arithmetic unit: field widths, operation and
// status codes, pipeline stage types and the divider and square root step functions.
// No dependencies.
package epau_pkg;

  localparam int unsigned DW = 32;
  localparam int unsigned FB = 16;
  localparam int unsigned EW = DW - 1;
  localparam int unsigned RW = 2 * DW;
  localparam int unsigned DIV_STEPS = DW;
  localparam int unsigned SQRT_STEPS = DW;
  localparam int unsigned TDI_W = ((DW + EW) * 2 + 7) / 8 * 8;
  localparam int unsigned TDO_W = (DW + EW + 7) / 8 * 8;
  localparam int unsigned RTW = DW + 4;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_SAT  = 2'd1,
    ST_DIV0 = 2'd2
  } status_e;

  typedef struct packed {
    action_e         op;
    logic            neg_prod;
    logic [DW-1:0]   am;
    logic [DW-1:0]   bm;
    logic [EW-1:0]   ea;
    logic [EW-1:0]   eb;
    logic [DW:0]     sum;
  } in_t;

  typedef struct packed {
    action_e         op;
    logic            neg_prod;
    logic [DW-1:0]   am;
    logic [DW-1:0]   bm;
    logic [EW-1:0]   ea;
    logic [EW-1:0]   eb;
    logic            sneg;
    logic [DW:0]     smag;
    logic [RW-1:0]   pv;
    logic [RW-2:0]   p1;
    logic [RW-2:0]   p2;
    logic [RW-1:0]   dd;
  } mul_t;

  typedef struct packed {
    logic            is_div;
    logic            div0;
    logic            val_neg;
    logic            mag_over;
    logic [DW-1:0]   mag;
    logic            u_big;
    logic [EW-1:0]   u;
    logic            v_big;
    logic [EW-1:0]   v;
  } side_t;

  typedef struct packed {
    logic [RW-1:0]   rem;
    logic [DW-1:0]   bits;
    logic [DW-1:0]   q;
    logic [RW-1:0]   d;
  } div_t;

  typedef struct packed {
    side_t           side;
    div_t            dv_a;
    div_t            dv_b;
    div_t            dv_c;
  } dst_t;

  typedef struct packed {
    logic [DW-1:0]   val;
    logic            vsat;
    logic            ebig;
    logic            div0;
    logic [EW-1:0]   u;
    logic [EW-1:0]   v;
  } sel_t;

  typedef struct packed {
    logic [DW-1:0]   val;
    logic            vsat;
    logic            ebig;
    logic            div0;
    logic [2*EW-1:0] uu;
    logic [2*EW-1:0] vv;
  } sqr_t;

  typedef struct packed {
    logic [DW-1:0]   val;
    logic            vsat;
    logic            ebig;
    logic            div0;
    logic [RW-1:0]   n;
    logic [RTW-1:0]  rem;
    logic [DW-1:0]   root;
  } rt_t;

  typedef struct packed {
    status_e         status;
    logic [EW-1:0]   error;
    logic [DW-1:0]   value;
  } out_t;

  // One restoring division step: shift in the next dividend bit and subtract if it fits.
  function automatic div_t div_step(div_t x);
    div_t        y;
    logic [RW:0] r2;
    r2 = {x.rem, x.bits[DW-1]};
    y = x;
    y.bits = {x.bits[DW-2:0], 1'b0};
    if (r2 >= {1'b0, x.d}) begin
      y.rem = RW'(r2 - {1'b0, x.d});
      y.q = {x.q[DW-2:0], 1'b1};
    end else begin
      y.rem = r2[RW-1:0];
      y.q = {x.q[DW-2:0], 1'b0};
    end
    return y;
  endfunction

  // One digit of the floor integer square root, two radicand bits per step.
  function automatic rt_t sqrt_step(rt_t x);
    rt_t            y;
    logic [RTW-1:0] rem2;
    logic [RTW-1:0] trial;
    rem2 = {x.rem[DW+1:0], x.n[RW-1:RW-2]};
    trial = {2'b00, x.root, 2'b01};
    y = x;
    y.n = {x.n[RW-3:0], 2'b00};
    if (rem2 >= trial) begin
      y.rem = rem2 - trial;
      y.root = {x.root[DW-2:0], 1'b1};
    end else begin
      y.rem = rem2;
      y.root = {x.root[DW-2:0], 1'b0};
    end
    return y;
  endfunction

endpackage

>>> rtl/error_propagating_arithmetic_unit.sv
// Top level of the error propagating arithmetic unit: the full pipeline and output skid.
// Depends on epau_pkg.
//
// Usage: words enter on the s_axis channel (two Q16.16 measurements with their standard
// errors, the operation in tuser) and leave on the m_axis channel (value, propagated
// error, status in tuser). Add and subtract combine errors in quadrature; multiply and
// divide combine the scaled error terms in quadrature. A zero divisor returns zeros with
// divide-by-zero status, and overflow saturates with saturated status.
// One word is accepted every clock cycle while the skid register is empty. Each result
// passes 71 register stages on its way to m_axis: two for operand decode and the
// multipliers, one to set up the dividers, 32 of restoring division (one quotient bit per
// stage), one for result selection, one for squaring, one for the sum, 32 of square root
// (one root bit per stage) and one final stage. Reset empties the pipeline and the skid
// register. When the receiver stalls, the skid register takes the waiting result and the
// pipeline freezes until it drains, so nothing is lost or repeated.
module error_propagating_arithmetic_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // Fields from bit 0: lhs_value, lhs_error, rhs_value, rhs_error, zero fill.
  input  logic [epau_pkg::TDI_W-1:0]  s_axis_tdata,
  // Fields from bit 0: action.
  input  logic [1:0]                  s_axis_tuser,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // Fields from bit 0: result_value, result_error, zero fill.
  output logic [epau_pkg::TDO_W-1:0]  m_axis_tdata,
  // Fields from bit 0: status.
  output logic [1:0]                  m_axis_tuser
);

  localparam int unsigned DW = epau_pkg::DW;
  localparam int unsigned EW = epau_pkg::EW;
  localparam int unsigned RW = epau_pkg::RW;
  localparam int unsigned FB = epau_pkg::FB;
  localparam int unsigned DS = epau_pkg::DIV_STEPS;
  localparam int unsigned SS = epau_pkg::SQRT_STEPS;
  localparam int unsigned TDO_W = epau_pkg::TDO_W;

  logic en;

  logic v1_q, v2_q, vsel_q, vsqr_q, vout_q;
  logic [DS:0] vdv_q;
  logic [SS:0] vrt_q;

  epau_pkg::in_t  s1_d, s1_q;
  epau_pkg::mul_t s2_d, s2_q;
  epau_pkg::dst_t dv_d [0:DS];
  epau_pkg::dst_t dv_q [0:DS];
  epau_pkg::sel_t sel_d, sel_q;
  epau_pkg::sqr_t sqr_d, sqr_q;
  epau_pkg::rt_t  rt_d [0:SS];
  epau_pkg::rt_t  rt_q [0:SS];
  epau_pkg::out_t out_d, out_q, skid_q;
  logic           skid_v_q;

  assign en = !skid_v_q;
  assign s_axis_tready = en;

  // Operand decode.
  always_comb begin
    logic [DW-1:0] a, b;
    a = s_axis_tdata[DW-1:0];
    b = s_axis_tdata[2*DW+EW-1:DW+EW];
    s1_d.op = epau_pkg::action_e'(s_axis_tuser);
    s1_d.neg_prod = a[DW-1] ^ b[DW-1];
    s1_d.am = a[DW-1] ? DW'(~a + 1'b1) : a;
    s1_d.bm = b[DW-1] ? DW'(~b + 1'b1) : b;
    s1_d.ea = s_axis_tdata[DW+EW-1:DW];
    s1_d.eb = s_axis_tdata[2*DW+2*EW-1:2*DW+EW];
    if (s1_d.op == epau_pkg::OP_SUB) begin
      s1_d.sum = {a[DW-1], a} - {b[DW-1], b};
    end else begin
      s1_d.sum = {a[DW-1], a} + {b[DW-1], b};
    end
  end

  // Multipliers.
  always_comb begin
    s2_d.op = s1_q.op;
    s2_d.neg_prod = s1_q.neg_prod;
    s2_d.am = s1_q.am;
    s2_d.bm = s1_q.bm;
    s2_d.ea = s1_q.ea;
    s2_d.eb = s1_q.eb;
    s2_d.sneg = s1_q.sum[DW];
    s2_d.smag = s1_q.sum[DW] ? (DW+1)'(~s1_q.sum + 1'b1) : s1_q.sum;
    s2_d.pv = RW'(s1_q.am) * RW'(s1_q.bm);
    s2_d.p1 = (RW-1)'(s1_q.ea) * (RW-1)'(s1_q.bm);
    s2_d.p2 = (RW-1)'(s1_q.eb) * (RW-1)'(s1_q.am);
    s2_d.dd = RW'(s1_q.bm) * RW'(s1_q.bm);
  end

  // Divider setup and the multiply and add results.
  always_comb begin
    logic [RW-1:0] pm;
    logic [RW-2:0] t1, t2;
    logic [RW-2:0] c_hi;
    pm = s2_q.pv >> FB;
    t1 = s2_q.p1 >> FB;
    t2 = s2_q.p2 >> FB;
    c_hi = s2_q.p2 >> FB;

    dv_d[0].dv_a.rem = RW'(s2_q.am >> (DW - FB));
    dv_d[0].dv_a.bits = DW'(s2_q.am << FB);
    dv_d[0].dv_a.q = '0;
    dv_d[0].dv_a.d = RW'(s2_q.bm);
    dv_d[0].dv_b.rem = RW'(s2_q.ea >> (DW - FB));
    dv_d[0].dv_b.bits = {s2_q.ea[DW-FB-1:0], {FB{1'b0}}};
    dv_d[0].dv_b.q = '0;
    dv_d[0].dv_b.d = RW'(s2_q.bm);
    dv_d[0].dv_c.rem = RW'(c_hi);
    dv_d[0].dv_c.bits = DW'(s2_q.p2 << FB);
    dv_d[0].dv_c.q = '0;
    dv_d[0].dv_c.d = s2_q.dd;

    dv_d[0].side.is_div = (s2_q.op == epau_pkg::OP_DIV);
    dv_d[0].side.div0 = (s2_q.bm == '0);
    unique case (s2_q.op)
      epau_pkg::OP_ADD, epau_pkg::OP_SUB: begin
        dv_d[0].side.val_neg = s2_q.sneg;
        dv_d[0].side.mag_over = s2_q.smag[DW];
        dv_d[0].side.mag = s2_q.smag[DW-1:0];
        dv_d[0].side.u_big = 1'b0;
        dv_d[0].side.u = s2_q.ea;
        dv_d[0].side.v_big = 1'b0;
        dv_d[0].side.v = s2_q.eb;
      end
      epau_pkg::OP_MUL: begin
        dv_d[0].side.val_neg = s2_q.neg_prod;
        dv_d[0].side.mag_over = |pm[RW-1:DW];
        dv_d[0].side.mag = pm[DW-1:0];
        dv_d[0].side.u_big = |t1[RW-2:EW];
        dv_d[0].side.u = t1[EW-1:0];
        dv_d[0].side.v_big = |t2[RW-2:EW];
        dv_d[0].side.v = t2[EW-1:0];
      end
      epau_pkg::OP_DIV: begin
        dv_d[0].side.val_neg = s2_q.neg_prod;
        dv_d[0].side.mag_over = dv_d[0].dv_a.rem >= dv_d[0].dv_a.d;
        dv_d[0].side.mag = '0;
        dv_d[0].side.u_big = dv_d[0].dv_b.rem >= dv_d[0].dv_b.d;
        dv_d[0].side.u = '0;
        dv_d[0].side.v_big = dv_d[0].dv_c.rem >= dv_d[0].dv_c.d;
        dv_d[0].side.v = '0;
      end
    endcase

    // Division stages, one quotient bit each.
    for (int unsigned k = 1; k <= DS; k++) begin
      dv_d[k].side = dv_q[k-1].side;
      dv_d[k].dv_a = epau_pkg::div_step(dv_q[k-1].dv_a);
      dv_d[k].dv_b = epau_pkg::div_step(dv_q[k-1].dv_b);
      dv_d[k].dv_c = epau_pkg::div_step(dv_q[k-1].dv_c);
    end
  end

  // Result selection and value saturation.
  always_comb begin
    epau_pkg::side_t sd;
    logic [DW-1:0]   lim;
    logic            over;
    sd = dv_q[DS].side;
    if (sd.is_div) begin
      sd.mag = dv_q[DS].dv_a.q;
      sd.u_big = sd.u_big | dv_q[DS].dv_b.q[DW-1];
      sd.u = dv_q[DS].dv_b.q[EW-1:0];
      sd.v_big = sd.v_big | dv_q[DS].dv_c.q[DW-1];
      sd.v = dv_q[DS].dv_c.q[EW-1:0];
    end
    lim = sd.val_neg ? {1'b1, {EW{1'b0}}} : {1'b0, {EW{1'b1}}};
    over = sd.mag_over || (sd.mag > lim);
    if (over) begin
      sel_d.val = sd.val_neg ? {1'b1, {EW{1'b0}}} : {1'b0, {EW{1'b1}}};
    end else begin
      sel_d.val = sd.val_neg ? DW'(~sd.mag + 1'b1) : sd.mag;
    end
    sel_d.vsat = over;
    sel_d.ebig = sd.u_big || sd.v_big;
    sel_d.div0 = sd.is_div && sd.div0;
    sel_d.u = sd.u;
    sel_d.v = sd.v;
  end

  // Squares of the error terms.
  always_comb begin
    sqr_d.val = sel_q.val;
    sqr_d.vsat = sel_q.vsat;
    sqr_d.ebig = sel_q.ebig;
    sqr_d.div0 = sel_q.div0;
    sqr_d.uu = (2*EW)'(sel_q.u) * (2*EW)'(sel_q.u);
    sqr_d.vv = (2*EW)'(sel_q.v) * (2*EW)'(sel_q.v);
  end

  // Sum of squares, then the square root stages.
  always_comb begin
    rt_d[0].val = sqr_q.val;
    rt_d[0].vsat = sqr_q.vsat;
    rt_d[0].ebig = sqr_q.ebig;
    rt_d[0].div0 = sqr_q.div0;
    rt_d[0].n = RW'(sqr_q.uu) + RW'(sqr_q.vv);
    rt_d[0].rem = '0;
    rt_d[0].root = '0;
    for (int unsigned k = 1; k <= SS; k++) begin
      rt_d[k] = epau_pkg::sqrt_step(rt_q[k-1]);
    end
  end

  // Error saturation and status.
  always_comb begin
    logic esat;
    esat = rt_q[SS].ebig || rt_q[SS].root[DW-1];
    if (rt_q[SS].div0) begin
      out_d.value = '0;
      out_d.error = '0;
      out_d.status = epau_pkg::ST_DIV0;
    end else begin
      out_d.value = rt_q[SS].val;
      out_d.error = esat ? {EW{1'b1}} : rt_q[SS].root[EW-1:0];
      out_d.status = (esat || rt_q[SS].vsat) ? epau_pkg::ST_SAT : epau_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      vdv_q <= '0;
      vsel_q <= 1'b0;
      vsqr_q <= 1'b0;
      vrt_q <= '0;
      vout_q <= 1'b0;
    end else if (en) begin
      v1_q <= s_axis_tvalid;
      v2_q <= v1_q;
      vdv_q <= {vdv_q[DS-1:0], v2_q};
      vsel_q <= vdv_q[DS];
      vsqr_q <= vsel_q;
      vrt_q <= {vrt_q[SS-1:0], vsqr_q};
      vout_q <= vrt_q[SS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_q <= s1_d;
      s2_q <= s2_d;
      for (int unsigned k = 0; k <= DS; k++) begin
        dv_q[k] <= dv_d[k];
      end
      sel_q <= sel_d;
      sqr_q <= sqr_d;
      for (int unsigned k = 0; k <= SS; k++) begin
        rt_q[k] <= rt_d[k];
      end
      out_q <= out_d;
      skid_q <= out_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      if (m_axis_tready) begin
        skid_v_q <= 1'b0;
      end
    end else if (vout_q && !m_axis_tready) begin
      skid_v_q <= 1'b1;
    end
  end

  assign m_axis_tvalid = skid_v_q || vout_q;
  assign m_axis_tdata = TDO_W'({(skid_v_q ? skid_q.error : out_q.error),
                                (skid_v_q ? skid_q.value : out_q.value)});
  assign m_axis_tuser = skid_v_q ? skid_q.status : out_q.status;

  a_div0_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == epau_pkg::ST_DIV0) |-> (m_axis_tdata == '0))
    else $error("Divide-by-zero result carries nonzero data.");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser != 2'd3))
    else $error("Result status holds an undefined code.");

  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_v_q) |-> $past(vout_q && !m_axis_tready))
    else $error("Skid register filled without a stalled result.");

  a_skid_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |=> $stable(vout_q) || !$past(skid_v_q))
    else $error("Pipeline moved while the skid register was full.");

endmodule
